@@ rtl/svp_pkg.sv @@
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, constants and the step table of the shape vector plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package svp_pkg;

  localparam int COORD_BITS = 16;
  localparam int SCALE_MAX  = 15;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_START_X    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_START_Y    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ROTATION   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SCALE      = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PLOT_COLOR = 3'd4;

  localparam logic [7:0] FRAC_START = 8'h80;
  localparam logic [3:0] ANGLE_FLIP = 4'hf;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN_X,
    ST_RUN_Y,
    ST_FLUSH
  } seq_state_t;

  // One unit step of the pen.
  typedef struct packed {
    logic       en;
    logic [1:0] dir;
  } move_t;

  // Commands to the output buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } ob_ctrl_t;

  // Status from the output buffer.
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic pend_valid;
  } ob_stat_t;

  function automatic logic [7:0] step_lookup(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:    v = 8'hff;
      5'd1:    v = 8'hfe;
      5'd2:    v = 8'hfa;
      5'd3:    v = 8'hf4;
      5'd4:    v = 8'hec;
      5'd5:    v = 8'he1;
      5'd6:    v = 8'hd4;
      5'd7:    v = 8'hc5;
      5'd8:    v = 8'hb4;
      5'd9:    v = 8'ha1;
      5'd10:   v = 8'h8d;
      5'd11:   v = 8'h78;
      5'd12:   v = 8'h61;
      5'd13:   v = 8'h49;
      5'd14:   v = 8'h31;
      5'd15:   v = 8'h18;
      default: v = 8'hff;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/svp_pen.sv @@
// ----------------------------------------------------------------------------
// svp_pen
// Pen position registers: loaded at shape start, stepped one unit per move.
// ----------------------------------------------------------------------------
`default_nettype none

module svp_pen (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic        [15:0] start_x,
  input  wire logic        [15:0] start_y,
  input  wire svp_pkg::move_t     mv,
  output logic             [15:0] pen_x,
  output logic             [15:0] pen_y
);
  import svp_pkg::*;

  logic [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0] pen_y_r, pen_y_nxt;

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (load) begin
      pen_x_nxt = COORD_BITS'(signed'(start_x));
      pen_y_nxt = COORD_BITS'(signed'(start_y));
    end else if (mv.en) begin
      // Odd direction moves along x, even along y.
      if (mv.dir[0]) begin
        pen_x_nxt = mv.dir[1] ? pen_x_r - COORD_BITS'(1) : pen_x_r + COORD_BITS'(1);
      end else begin
        pen_y_nxt = mv.dir[1] ? pen_y_r + COORD_BITS'(1) : pen_y_r - COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  assign pen_x = 16'(pen_x_r);
  assign pen_y = 16'(pen_y_r);

endmodule

`default_nettype wire

@@ rtl/svp_outbuf.sv @@
// ----------------------------------------------------------------------------
// svp_outbuf
// Output register with one pixel of lookahead so the final pixel of a byte
// can be marked when the byte finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module svp_outbuf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire svp_pkg::ob_ctrl_t    ctrl,
  input  wire logic          [15:0] px_in,
  input  wire logic          [15:0] py_in,
  input  wire logic           [7:0] color_in,
  output svp_pkg::ob_stat_t         stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed        [15:0] out_pixel_x,
  output logic signed        [15:0] out_pixel_y,
  output logic                [7:0] out_pixel_color,
  output logic                      out_last_of_run
);
  import svp_pkg::*;

  logic        pend_valid_r, pend_valid_nxt;
  logic [15:0] pend_x_r, pend_y_r;
  logic [7:0]  pend_c_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_x_r, out_y_r;
  logic [7:0]  out_c_r;
  logic        out_last_r;
  logic        out_free;
  logic        out_load;

  assign out_free = !out_valid_r || out_ready;

  assign stat.push_ok    = !pend_valid_r || out_free;
  assign stat.flush_ok   = out_free;
  assign stat.pend_valid = pend_valid_r;

  // A push displaces the held pixel into the output register; a flush sends
  // the held pixel out as the final one of its byte.
  assign out_load = pend_valid_r && (ctrl.push || ctrl.flush);

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (ctrl.push) begin
      pend_valid_nxt = 1'b1;
    end else if (ctrl.flush) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      pend_x_r <= px_in;
      pend_y_r <= py_in;
      pend_c_r <= color_in;
    end
    if (out_load) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_c_r    <= pend_c_r;
      out_last_r <= ctrl.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_c_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

@@ rtl/svp_seq.sv @@
// ----------------------------------------------------------------------------
// svp_seq
// Sequencer: walks the vectors of one byte, runs the scale iterations and
// steps the shared accumulator adder once per cycle unless a push stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module svp_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic          [7:0] in_shape_byte,
  input  wire logic          [7:0] rotation_code,
  input  wire logic          [3:0] scale_factor,
  input  wire svp_pkg::ob_stat_t   ob_stat,
  output svp_pkg::ob_ctrl_t        ob_ctrl,
  output svp_pkg::move_t           mv,
  output logic                     load_pen
);
  import svp_pkg::*;

  seq_state_t state_r, state_nxt;
  logic       started_r, started_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [3:0] quad_r, quad_nxt;
  logic [7:0] xs_r, xs_nxt;
  logic [7:0] ys_r, ys_nxt;
  logic [3:0] scale_r, scale_nxt;
  logic [3:0] iter_r, iter_nxt;
  logic [7:0] xf_r, xf_nxt;
  logic [7:0] yf_r, yf_nxt;

  logic       accept;
  logic [3:0] ang;
  logic [8:0] sum;
  logic       carry;
  logic       plot;
  logic [1:0] quad_use;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ang      = rotation_code[3:0];
  assign plot     = rem_r[2];

  // The one accumulator adder: x phase adds xs plus one, y phase adds ys.
  always_comb begin
    if (state_r == ST_RUN_Y) begin
      sum      = {1'b0, yf_r} + {1'b0, ys_r};
      quad_use = quad_r[1:0] + 2'd1;
    end else begin
      sum      = {1'b0, xf_r} + {1'b0, xs_r} + 9'd1;
      quad_use = quad_r[1:0];
    end
  end
  assign carry = sum[8];

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    rem_nxt     = rem_r;
    quad_nxt    = quad_r;
    xs_nxt      = xs_r;
    ys_nxt      = ys_r;
    scale_nxt   = scale_r;
    iter_nxt    = iter_r;
    xf_nxt      = xf_r;
    yf_nxt      = yf_r;
    ob_ctrl     = '0;
    mv          = '0;
    mv.dir      = rem_r[1:0] + quad_use;
    load_pen    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_shape_byte == 8'd0) begin
            started_nxt = 1'b0;
          end else begin
            load_pen    = !started_r;
            started_nxt = 1'b1;
            rem_nxt     = in_shape_byte;
            quad_nxt    = rotation_code[7:4];
            xs_nxt      = step_lookup({1'b0, ang});
            ys_nxt      = step_lookup({1'b0, ang ^ ANGLE_FLIP} + 5'd1) + 8'd1;
            scale_nxt   = (scale_factor > 4'(SCALE_MAX)) ? 4'(SCALE_MAX) : scale_factor;
            iter_nxt    = 4'd0;
            xf_nxt      = FRAC_START;
            yf_nxt      = FRAC_START;
            state_nxt   = (scale_nxt == 4'd0) ? ST_FLUSH : ST_RUN_X;
          end
        end
      end
      ST_RUN_X: begin
        if (!(carry && plot && !ob_stat.push_ok)) begin
          mv.en        = carry;
          ob_ctrl.push = carry && plot;
          xf_nxt       = sum[7:0];
          state_nxt    = ST_RUN_Y;
        end
      end
      ST_RUN_Y: begin
        if (!(carry && plot && !ob_stat.push_ok)) begin
          mv.en        = carry;
          ob_ctrl.push = carry && plot;
          yf_nxt       = sum[7:0];
          if (iter_r + 4'd1 == scale_r) begin
            // End of this vector: take the next three bits.
            iter_nxt  = 4'd0;
            rem_nxt   = rem_r >> 3;
            xf_nxt    = FRAC_START;
            yf_nxt    = FRAC_START;
            state_nxt = (rem_r[7:3] == 5'd0) ? ST_FLUSH : ST_RUN_X;
          end else begin
            iter_nxt  = iter_r + 4'd1;
            state_nxt = ST_RUN_X;
          end
        end
      end
      ST_FLUSH: begin
        if (!ob_stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (ob_stat.flush_ok) begin
          ob_ctrl.flush = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quad_r  <= quad_nxt;
    xs_r    <= xs_nxt;
    ys_r    <= ys_nxt;
    scale_r <= scale_nxt;
    iter_r  <= iter_nxt;
    xf_r    <= xf_nxt;
    yf_r    <= yf_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/shape_vector_plotter_unit.sv @@
// ----------------------------------------------------------------------------
// shape_vector_plotter_unit
// Shape-table byte plotter: decodes each byte into vectors and emits the
// pixels they plot.
// ----------------------------------------------------------------------------
// One shape byte is taken per transaction on the in_ channel, and each plotted
// pixel leaves as one transaction on the out_ channel, with out_last_of_run set
// on the final pixel of that byte. A single accumulator adder under the
// sequencer handles one half-iteration (x then y) per cycle unless the output
// side holds off a pixel, and the input side stays busy until every vector of
// a nonzero byte is done (a byte holds one to three vectors, scale at most 15).
// A zero byte ends the shape. Configuration writes are to be made only while
// the block is idle.
`default_nettype none

module shape_vector_plotter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [svp_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire logic [svp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                          [7:0] in_shape_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed                       [15:0] out_pixel_x,
  output logic signed                       [15:0] out_pixel_y,
  output logic                               [7:0] out_pixel_color,
  output logic                                     out_last_of_run
);
  import svp_pkg::*;

  logic [15:0] start_x_r, start_y_r;
  logic [7:0]  rotation_r;
  logic [3:0]  scale_r;
  logic [7:0]  color_r;

  ob_ctrl_t    ob_ctrl;
  ob_stat_t    ob_stat;
  move_t       mv;
  logic        load_pen;
  logic [15:0] pen_x, pen_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= '0;
      start_y_r  <= '0;
      rotation_r <= '0;
      scale_r    <= 4'd1;
      color_r    <= 8'd127;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_X:    start_x_r  <= cfg_wdata;
        CFG_START_Y:    start_y_r  <= cfg_wdata;
        CFG_ROTATION:   rotation_r <= cfg_wdata[7:0];
        CFG_SCALE:      scale_r    <= cfg_wdata[3:0];
        CFG_PLOT_COLOR: color_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  svp_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_shape_byte (in_shape_byte),
    .rotation_code (rotation_r),
    .scale_factor  (scale_r),
    .ob_stat       (ob_stat),
    .ob_ctrl       (ob_ctrl),
    .mv            (mv),
    .load_pen      (load_pen)
  );

  svp_pen u_pen (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load_pen),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .mv      (mv),
    .pen_x   (pen_x),
    .pen_y   (pen_y)
  );

  svp_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ob_ctrl),
    .px_in           (pen_x),
    .py_in           (pen_y),
    .color_in        (color_r),
    .stat            (ob_stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

@@ verif/shape_vector_plotter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_vector_plotter_unit_test
// Drives shape bytes into the plotter under several register settings and
// checks every plotted pixel against a cycle-free model of the pen.
// ----------------------------------------------------------------------------
module shape_vector_plotter_unit_test;
  import svp_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 100;

  // Angle steps, index 16 repeats the full step.
  localparam logic [16:0][7:0] ANGLE_STEP = {
    8'hff, 8'h18, 8'h31, 8'h49, 8'h61, 8'h78, 8'h8d, 8'ha1, 8'hb4,
    8'hc5, 8'hd4, 8'he1, 8'hec, 8'hf4, 8'hfa, 8'hfe, 8'hff
  };

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  color;
    logic        last;
  } pixel_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               in_shape_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [15:0]       out_pixel_x;
  logic signed [15:0]       out_pixel_y;
  logic [7:0]               out_pixel_color;
  logic                     out_last_of_run;

  // Register shadows and pen state of the model.
  logic [15:0] reg_start_x  = 16'd0;
  logic [15:0] reg_start_y  = 16'd0;
  logic [7:0]  reg_rotation = 8'd0;
  logic [3:0]  reg_scale    = 4'd1;
  logic [7:0]  reg_color    = 8'd127;
  logic [15:0] pen_x        = 16'd0;
  logic [15:0] pen_y        = 16'd0;
  bit          shape_open   = 1'b0;

  pixel_t expected_pixels[$];
  pixel_t held_pixel;
  bit     held_valid = 1'b0;

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int out_hold_left  = 0;
  int quiet_cycles   = 0;
  int angle_next     = 0;

  shape_vector_plotter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_shape_byte   (in_shape_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One pen move: plot first when the vector has its plot bit, then step.
  // The newest pixel is held back so the final one of a byte can be marked.
  function automatic void step_pen(input logic [7:0] rem, input logic [7:0] quad);
    logic [7:0] dir;
    if (rem[2]) begin
      if (held_valid) expected_pixels.push_back(held_pixel);
      held_pixel = '{pen_x, pen_y, reg_color, 1'b0};
      held_valid = 1'b1;
    end
    dir = rem + quad;
    if (dir[0]) pen_x = dir[1] ? pen_x - 16'd1 : pen_x + 16'd1;
    else        pen_y = dir[1] ? pen_y + 16'd1 : pen_y - 16'd1;
  endfunction

  function automatic void trace_shape_byte(input logic [7:0] shape_byte);
    logic [7:0] rem;
    logic [7:0] quad;
    logic [7:0] x_step;
    logic [7:0] y_step;
    logic [7:0] x_frac;
    logic [7:0] y_frac;
    logic [8:0] x_sum;
    logic [8:0] y_sum;
    logic [4:0] y_index;
    int         iter;
    if (shape_byte == 8'd0) begin
      shape_open = 1'b0;
      return;
    end
    if (!shape_open) begin
      pen_x      = reg_start_x;
      pen_y      = reg_start_y;
      shape_open = 1'b1;
    end
    quad    = {4'd0, reg_rotation[7:4]};
    x_step  = ANGLE_STEP[reg_rotation[3:0]];
    y_index = {1'b0, reg_rotation[3:0] ^ ANGLE_FLIP} + 5'd1;
    y_step  = ANGLE_STEP[y_index] + 8'd1;
    rem     = shape_byte;
    while (rem != 8'd0) begin
      x_frac = FRAC_START;
      y_frac = FRAC_START;
      for (iter = 0; iter < int'(reg_scale); iter++) begin
        x_sum = {1'b0, x_frac} + {1'b0, x_step} + 9'd1;
        y_sum = {1'b0, y_frac} + {1'b0, y_step};
        if (x_sum[8]) step_pen(rem, quad);
        x_frac = x_sum[7:0];
        if (y_sum[8]) step_pen(rem, quad + 8'd1);
        y_frac = y_sum[7:0];
      end
      rem = rem >> 3;
    end
    if (held_valid) begin
      held_pixel.last = 1'b1;
      expected_pixels.push_back(held_pixel);
      held_valid = 1'b0;
    end
  endfunction

  // Sends one shape byte and returns at the edge where it was taken.
  task automatic send_byte(input logic [7:0] shape_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_shape_byte <= shape_byte;
    do @(posedge clk); while (!in_ready);
    trace_shape_byte(shape_byte);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // A byte that plots nothing may still be running, so let it finish first.
  task automatic apply_config(input logic [15:0] start_x, input logic [15:0] start_y,
                              input logic [7:0] rotation, input logic [3:0] scale,
                              input logic [7:0] color);
    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    write_reg(CFG_START_X, start_x);
    write_reg(CFG_START_Y, start_y);
    write_reg(CFG_ROTATION, {8'd0, rotation});
    write_reg(CFG_SCALE, {12'd0, scale});
    write_reg(CFG_PLOT_COLOR, {8'd0, color});
    cfg_we       <= 1'b0;
    reg_start_x  = start_x;
    reg_start_y  = start_y;
    reg_rotation = rotation;
    reg_scale    = scale;
    reg_color    = color;
  endtask

  task automatic test_reset_settings();
    send_byte(8'h04);
    send_byte(8'hff);
    send_byte(8'h00);
  endtask

  task automatic test_coordinate_wrap();
    apply_config(16'h7fff, 16'h8000, 8'h00, 4'd15, 8'hff);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h00);
    apply_config(16'h8000, 16'h7fff, 8'h00, 4'd15, 8'h00);
    send_byte(8'h07);
    send_byte(8'h00);
    send_byte(8'h06);
    send_byte(8'h00);
  endtask

  task automatic test_scale_zero();
    apply_config(16'd3, 16'd3, 8'h5a, 4'd0, 8'h11);
    send_byte(8'hff);
    send_byte(8'h24);
    send_byte(8'h00);
  endtask

  // The second setting lands mid-shape, so its start position must not apply.
  task automatic test_rotation_quadrants();
    apply_config(16'd100, -16'sd100, 8'h0f, 4'd15, 8'h3c);
    send_byte(8'he4);
    apply_config(16'd5, 16'd5, 8'hf8, 4'd7, 8'hc3);
    send_byte(8'he4);
    send_byte(8'h00);
    apply_config(16'd5, 16'd5, 8'h38, 4'd15, 8'h81);
    send_byte(8'he4);
    send_byte(8'h00);
  endtask

  // The receiver stalls long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(16'h1234, 16'hfedc, 8'h2b, 4'd15, 8'h5a);
    out_hold_left = 400;
    for (i = 0; i < 8; i++) send_byte(8'he4 | 8'($urandom_range(3)));
    wait_drained();
    send_byte(8'hfc);
    send_byte(8'h00);
  endtask

  task automatic test_random_shapes(input int sender_pct, input int receiver_pct,
                                    input int n_items);
    int         group;
    int         i;
    logic [7:0] shape_byte;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (group = 0; group < 8; group++) begin
      if (group == 0) begin
        apply_config(16'h8000, 16'h7fff, 8'hff, 4'd15, 8'h00);
      end else if (group == 1) begin
        apply_config(16'h7fff, 16'h8000, 8'h00, 4'd1, 8'hff);
      end else begin
        apply_config(16'($urandom), 16'($urandom),
                     {4'($urandom_range(15)), 4'(angle_next)},
                     4'($urandom_range(15, 1)), 8'($urandom_range(255)));
        angle_next++;
      end
      // Shapes of random bytes, closed now and then by a zero byte.
      for (i = 0; i < n_items / 8; i++) begin
        if ($urandom_range(7) == 0) shape_byte = 8'd0;
        else shape_byte = 8'($urandom_range(255, 1));
        send_byte(shape_byte);
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_left > 0) begin
        out_ready <= 1'b0;
        out_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected pixel: expected none, got x %0d y %0d", $realtime,
                 out_pixel_x, out_pixel_y);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_x !== want.x) begin
          mismatch_count++;
          $display("%0t pixel_x expected %0d got %0d", $realtime, $signed(want.x),
                   out_pixel_x);
        end
        if (out_pixel_y !== want.y) begin
          mismatch_count++;
          $display("%0t pixel_y expected %0d got %0d", $realtime, $signed(want.y),
                   out_pixel_y);
        end
        if (out_pixel_color !== want.color) begin
          mismatch_count++;
          $display("%0t pixel_color expected %0d got %0d", $realtime, want.color,
                   out_pixel_color);
        end
        if (out_last_of_run !== want.last) begin
          mismatch_count++;
          $display("%0t last_of_run expected %0b got %0b", $realtime, want.last,
                   out_last_of_run);
        end
      end
    end
  end

  // Any long stretch without a transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_shape_byte = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 69;
    test_reset_settings();
    test_coordinate_wrap();
    test_scale_zero();
    test_rotation_quadrants();

    test_random_shapes(20, 69, 152);
    test_random_shapes(69, 20, 152);
    test_random_shapes(0, 0, 152);
    test_output_backpressure();

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/svp_pkg.sv
rtl/svp_pen.sv
rtl/svp_outbuf.sv
rtl/svp_seq.sv
rtl/shape_vector_plotter_unit.sv
verif/shape_vector_plotter_unit_test.sv
